// ===== rtl/core/cerl_pkg.sv =====
// ----------------------------------------------------------------------------
// cerl_pkg
// Shared types, constants and elaboration-time functions for the row
// cross-entropy loss block: field widths, queue entry format, ln table build.
// ----------------------------------------------------------------------------
package cerl_pkg;

    // Field widths
    localparam int PRED_W = 17;
    localparam int TGT_W  = 18;
    localparam int WGT_W  = 17;
    localparam int EPS_W  = 15;
    localparam int SUM_W  = 32;
    localparam int LN_W   = 32;
    localparam int NEG_W  = 37;
    localparam int FRAC_W = 16;
    localparam int SHF_W  = 5;

    // Defaults
    localparam int LOG_TABLE_ENTRIES_DEF = 256;
    localparam int MID_DEPTH             = 4;
    localparam int OUT_DEPTH             = 2;

    // Register map
    localparam int                 CFG_DATA_W  = 32;
    localparam int                 CFG_ADDR_W  = 2;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 15'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EPSILON = 2'd0;

    // One classified item between the front end and the loss pipeline
    typedef struct packed {
        logic [FRAC_W-1:0] frac;    // mantissa fraction of the clipped prediction
        logic [SHF_W-1:0]  shift;   // 16 - index of its top set bit
        logic [WGT_W-1:0]  weight;  // positive target, zero when it adds nothing
        logic              last;    // closes the row
    } t_item;

    // Restoring divide, used only when building constants
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], a[j]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/n) in Q32 from the atanh series
    function automatic logic [LN_W-1:0] ln_entry(input int i, input int n);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] prod;
        num = 64'(i);
        den = 64'(n);
        z   = udiv64(num << 32, (den << 1) + num);
        prod = z * z;
        z2  = prod >> 32;
        pw  = z;
        acc = '0;
        for (int k = 0; k < 64; k++) begin
            if (pw != 64'd0) begin
                acc  = acc + udiv64(pw, 64'(2 * k + 1));
                prod = pw * z2;
                pw   = prod >> 32;
            end
        end
        acc = acc << 1;
        return acc[LN_W-1:0];
    endfunction

endpackage

// ===== rtl/core/cerl_fifo.sv =====
// ----------------------------------------------------------------------------
// cerl_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cerl_fifo
    import cerl_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/cerl_front.sv =====
// ----------------------------------------------------------------------------
// cerl_front
// Clips the prediction to [epsilon, 1 - epsilon], normalizes it to a
// mantissa fraction and shift, and screens out nonpositive targets.
// ----------------------------------------------------------------------------
module cerl_front
    import cerl_pkg::*;
(
    input  logic [EPS_W-1:0]  i_eps,
    input  logic [PRED_W-1:0] i_prediction,
    input  logic [TGT_W-1:0]  i_target,
    input  logic              i_last_class,
    output t_item             o_item
);

    logic [PRED_W-1:0] w_lo;
    logic [PRED_W-1:0] w_hi;
    logic [PRED_W-1:0] w_p;
    logic [SHF_W-1:0]  w_top;
    logic [PRED_W-1:0] w_m;
    logic              w_active;

    // clip bounds; a zero epsilon still keeps the lower bound at one
    assign w_lo = (i_eps == '0) ? PRED_W'(1) : PRED_W'(i_eps);
    assign w_hi = PRED_W'(65536) - PRED_W'(i_eps);

    always_comb begin
        w_p = i_prediction;
        if (w_p > w_hi) begin
            w_p = w_hi;
        end
        if (w_p < w_lo) begin
            w_p = w_lo;
        end
    end

    // top set bit of the clipped value
    always_comb begin
        w_top = '0;
        for (int j = 0; j < PRED_W; j++) begin
            if (w_p[j]) begin
                w_top = SHF_W'(j);
            end
        end
    end

    assign w_m      = w_p << (SHF_W'(16) - w_top);
    assign w_active = !i_target[TGT_W-1] && (i_target != '0);

    // classified item
    always_comb begin
        o_item.frac   = w_m[FRAC_W-1:0];
        o_item.shift  = SHF_W'(16) - w_top;
        o_item.weight = w_active ? i_target[WGT_W-1:0] : '0;
        o_item.last   = i_last_class;
    end

endmodule

// ===== rtl/core/cerl_back.sv =====
// ----------------------------------------------------------------------------
// cerl_back
// Loss pipeline: table interpolation of ln, -ln p, weighting by the target
// and the saturating row sum. The whole pipeline holds while the result
// queue is full.
// ----------------------------------------------------------------------------
module cerl_back
    import cerl_pkg::*;
#(
    parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_item_valid,
    output logic             o_item_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output logic [SUM_W-1:0] o_out_data
);

    localparam int N  = LOG_TABLE_ENTRIES;
    localparam int TW = $clog2(N + 1);
    localparam int IW = $clog2(N);
    localparam int SW = FRAC_W + TW;
    localparam int PL_W = WGT_W + LN_W;
    localparam int PH_W = WGT_W + NEG_W - LN_W;
    localparam int TERM_W = PH_W + 1;

    // ln(1 + i/N) table, built at elaboration
    logic [LN_W-1:0] w_tab [0:N];
    for (genvar gi = 0; gi <= N; gi++) begin : g_tab
        localparam logic [LN_W-1:0] LV = ln_entry(gi, N);
        assign w_tab[gi] = LV;
    end

    logic w_adv;
    assign w_adv      = !i_out_full;
    assign o_item_pop = w_adv && i_item_valid;

    // stage 1: table index and interpolation weight
    logic [SW-1:0]     w_scaled;
    logic              r_v1;
    logic [IW-1:0]     r_idx1;
    logic [FRAC_W-1:0] r_r1;
    logic [SHF_W-1:0]  r_k1;
    logic [WGT_W-1:0]  r_w1;
    logic              r_l1;

    assign w_scaled = SW'(i_item.frac) * SW'(N);

    // stage 2: table read
    logic [LN_W-1:0]   w_t0;
    logic [LN_W-1:0]   w_t1;
    logic              r_v2;
    logic [LN_W-1:0]   r_t0_2;
    logic [LN_W-1:0]   r_diff2;
    logic [FRAC_W-1:0] r_r2;
    logic [SHF_W-1:0]  r_k2;
    logic [WGT_W-1:0]  r_w2;
    logic              r_l2;

    assign w_t0 = w_tab[TW'(r_idx1)];
    assign w_t1 = w_tab[TW'(r_idx1) + TW'(1)];

    // stage 3: slope product and whole octaves
    logic [LN_W+FRAC_W-1:0] w_slope;
    logic                   r_v3;
    logic [LN_W-1:0]        r_t0_3;
    logic [LN_W-1:0]        r_part3;
    logic [NEG_W-1:0]       r_whole3;
    logic [WGT_W-1:0]       r_w3;
    logic                   r_l3;

    assign w_slope = (LN_W + FRAC_W)'(r_diff2) * (LN_W + FRAC_W)'(r_r2);

    // stage 4: ln of the mantissa
    logic               r_v4;
    logic [LN_W:0]      r_lnm4;
    logic [NEG_W-1:0]   r_whole4;
    logic [WGT_W-1:0]   r_w4;
    logic               r_l4;

    // stage 5: -ln p, floored at zero
    logic               r_v5;
    logic [NEG_W-1:0]   r_neg5;
    logic [WGT_W-1:0]   r_w5;
    logic               r_l5;

    // stage 6: weight products, split at bit 32
    logic               r_v6;
    logic [PL_W-1:0]    r_pl6;
    logic [PH_W-1:0]    r_ph6;
    logic               r_l6;

    // stage 7: term in Q16.16
    logic               r_v7;
    logic [TERM_W-1:0]  r_term7;
    logic               r_l7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_item_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_idx1  <= w_scaled[FRAC_W+IW-1:FRAC_W];
            r_r1    <= w_scaled[FRAC_W-1:0];
            r_k1    <= i_item.shift;
            r_w1    <= i_item.weight;
            r_l1    <= i_item.last;

            r_t0_2  <= w_t0;
            r_diff2 <= (w_t1 > w_t0) ? w_t1 - w_t0 : '0;
            r_r2    <= r_r1;
            r_k2    <= r_k1;
            r_w2    <= r_w1;
            r_l2    <= r_l1;

            r_t0_3   <= r_t0_2;
            r_part3  <= w_slope[LN_W+FRAC_W-1:FRAC_W];
            r_whole3 <= NEG_W'(r_k2) * NEG_W'(w_tab[N]);
            r_w3     <= r_w2;
            r_l3     <= r_l2;

            r_lnm4   <= {1'b0, r_t0_3} + {1'b0, r_part3};
            r_whole4 <= r_whole3;
            r_w4     <= r_w3;
            r_l4     <= r_l3;

            r_neg5 <= (r_whole4 > NEG_W'(r_lnm4)) ? r_whole4 - NEG_W'(r_lnm4) : '0;
            r_w5   <= r_w4;
            r_l5   <= r_l4;

            r_pl6 <= PL_W'(r_w5) * PL_W'(r_neg5[LN_W-1:0]);
            r_ph6 <= PH_W'(r_w5) * PH_W'(r_neg5[NEG_W-1:LN_W]);
            r_l6  <= r_l5;

            r_term7 <= TERM_W'(r_ph6) + TERM_W'(r_pl6[PL_W-1:LN_W]);
            r_l7    <= r_l6;
        end
    end

    // stage 8: saturating row sum and result
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W:0]   w_add;
    logic [SUM_W-1:0] w_sum;

    assign w_add = {1'b0, r_sum} + (SUM_W + 1)'(r_term7);
    assign w_sum = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_adv && r_v7) begin
            r_sum <= r_l7 ? '0 : w_sum;
        end
    end

    assign o_out_push = w_adv && r_v7 && r_l7;
    assign o_out_data = w_sum;

    // the row sum is cleared once its row is delivered
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |=> (r_sum == '0))
        else $error("row sum not cleared after row end");

    // within a row the sum never shrinks
    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v7 && !r_l7) |=> (r_sum >= $past(r_sum)))
        else $error("row sum decreased within a row");

    // a held pipeline keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> ($stable(r_v7) && $stable(r_term7) && $stable(r_sum)))
        else $error("pipeline moved while held");

endmodule

// ===== rtl/core/cross_entropy_row_loss.sv =====
// ----------------------------------------------------------------------------
// cross_entropy_row_loss
// Streaming categorical cross-entropy: one (prediction, target) transaction
// per class, one row loss transaction per row.
// ----------------------------------------------------------------------------
// The block takes one class transaction per clock while full is low: the
// prediction is clipped to [epsilon, 1 - epsilon], and a positive target adds
// target * -ln(p) to a saturating Q16.16 row sum; the transaction marked
// last_class releases the row loss. The front end is combinational: a class
// is clipped and classified on its way into a 4-entry queue at the edge that
// accepts it, then passes 8 pipeline stages (index scaling, ln table read,
// slope and octave multiplies, mantissa ln add, -ln subtract, weight
// multiplies, term add, sum); the sum stage pushes the row loss into the
// result queue when its last class reaches it. The loss pipeline advances
// as a whole only while the 2-entry result queue has room, so sustained
// throughput is one class per cycle as long as results are popped. Epsilon
// resets to 1; write it only while no row is in flight. An epsilon of zero
// keeps the lower clip bound at one.
// ----------------------------------------------------------------------------
module cross_entropy_row_loss
    import cerl_pkg::*;
#(
    parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // class transactions
    input  logic                  push,
    output logic                  full,
    input  logic [PRED_W-1:0]     i_prediction,
    input  logic signed [TGT_W-1:0] i_target,
    input  logic                  i_last_class,
    // row loss transactions
    input  logic                  pop,
    output logic                  empty,
    output logic [SUM_W-1:0]      o_row_loss,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [EPS_W-1:0] r_eps;
    t_item            w_item_in;
    t_item            w_item_q;
    logic             w_mid_empty;
    logic             w_mid_pop;
    logic             w_out_full;
    logic             w_out_push;
    logic [SUM_W-1:0] w_out_data;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_EPSILON) ? CFG_DATA_W'(r_eps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == REG_EPSILON) begin
                r_eps <= pwdata[EPS_W-1:0];
            end
        end
    end

    // clip and classify
    cerl_front u_front (
        .i_eps        (r_eps),
        .i_prediction (i_prediction),
        .i_target     (i_target),
        .i_last_class (i_last_class),
        .o_item       (w_item_in)
    );

    // queue between front end and loss pipeline
    cerl_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_item_in),
        .o_full  (full),
        .i_pop   (w_mid_pop),
        .o_data  (w_item_q),
        .o_empty (w_mid_empty)
    );

    // loss pipeline
    cerl_back #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item_q),
        .i_item_valid (!w_mid_empty),
        .o_item_pop   (w_mid_pop),
        .i_out_full   (w_out_full),
        .o_out_push   (w_out_push),
        .o_out_data   (w_out_data)
    );

    // result queue
    cerl_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_data),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_row_loss),
        .o_empty (empty)
    );

endmodule

// ===== bench/tb_cross_entropy_row_loss.sv =====
// ----------------------------------------------------------------------------
// tb_cross_entropy_row_loss
// Self-checking bench for the row cross-entropy loss block. Class
// transactions go in through the push/full queue port and row losses come
// back through the empty/pop port. A row loss tracker clips each prediction,
// works out target * -ln(p) from its own interpolated ln table, and keeps a
// saturating row sum; every popped row loss is checked against the oldest
// loss the tracker expects. Epsilon is rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_cross_entropy_row_loss;
    import cerl_pkg::*;

    localparam int LN_ENTRIES   = 256;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 30;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_ITEMS  = 205;
    localparam int LONG_ROW_LEN = 100;

    // Tracks the running row sum and the row losses still owed by the block
    class row_loss_tracker;
        bit [31:0]  ln_tab [0:LN_ENTRIES];
        bit [14:0]  eps;
        bit [31:0]  row_sum;
        bit [31:0]  losses_due [$];
        int         errors;

        function new();
            bit [63:0] z;
            bit [63:0] z2;
            bit [63:0] pw;
            bit [63:0] acc;
            // ln(1 + i/N) in Q32 via 2 * atanh(i / (2N + i))
            for (int i = 0; i <= LN_ENTRIES; i++) begin
                z   = (64'(i) << 32) / (64'(2 * LN_ENTRIES) + 64'(i));
                z2  = (z * z) >> 32;
                pw  = z;
                acc = 0;
                for (int k = 0; k < 64 && pw != 0; k++) begin
                    acc += pw / 64'(2 * k + 1);
                    pw  = (pw * z2) >> 32;
                end
                ln_tab[i] = 32'(acc << 1);
            end
            eps     = 15'd1;
            row_sum = 0;
            errors  = 0;
        endfunction

        function void set_epsilon(bit [14:0] v);
            eps = v;
        endfunction

        // -ln(p / 65536) in Q32 for p in 1..65536
        function bit [63:0] neg_ln_q32(bit [16:0] p);
            int        msb;
            int        idx;
            bit [63:0] m;
            bit [63:0] frac;
            bit [63:0] scaled;
            bit [63:0] r;
            bit [63:0] ln_m;
            bit [63:0] whole;
            msb = 0;
            for (int b = 0; b < 17; b++)
                if (p[b]) msb = b;
            m      = 64'(p) << (16 - msb);
            frac   = (m - 64'd65536) & 64'hFFFF;
            scaled = frac * LN_ENTRIES;
            idx    = int'(scaled >> 16);
            r      = scaled & 64'hFFFF;
            if (idx >= LN_ENTRIES) idx = LN_ENTRIES - 1;
            ln_m = 64'(ln_tab[idx]);
            if (ln_tab[idx + 1] > ln_tab[idx])
                ln_m += (64'(ln_tab[idx + 1] - ln_tab[idx]) * r) >> 16;
            whole = 64'(16 - msb) * 64'(ln_tab[LN_ENTRIES]);
            return (whole > ln_m) ? whole - ln_m : 64'd0;
        endfunction

        // One accepted class transaction
        function void take_class(bit [16:0] pred, bit [17:0] tgt, bit last);
            bit [31:0] p;
            bit [31:0] lo;
            bit [31:0] hi;
            bit [63:0] term;
            bit [63:0] s;
            p  = 32'(pred);
            lo = (eps == 0) ? 32'd1 : 32'(eps);
            hi = 32'd65536 - 32'(eps);
            if (p > hi) p = hi;
            if (p < lo) p = lo;
            // only a positive target adds to the row
            if (!tgt[17] && tgt != 0) begin
                term    = (64'(tgt) * neg_ln_q32(17'(p))) >> 32;
                s       = 64'(row_sum) + term;
                row_sum = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(s);
            end
            if (last) begin
                losses_due.push_back(row_sum);
                row_sum = 0;
            end
        endfunction

        // One popped row loss transaction
        function void match_loss(bit [31:0] got);
            bit [31:0] want;
            if (losses_due.size() == 0) begin
                $error("row_loss: no row loss expected, actual %0h", got);
                errors++;
                return;
            end
            want = losses_due.pop_front();
            if (got !== want) begin
                $error("row_loss mismatch: expected %0h actual %0h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      push         = 1'b0;
    logic                      full;
    logic [PRED_W-1:0]         i_prediction = '0;
    logic signed [TGT_W-1:0]   i_target     = '0;
    logic                      i_last_class = 1'b0;
    logic                      pop          = 1'b0;
    logic                      empty;
    logic [SUM_W-1:0]          o_row_loss;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0]     paddr        = REG_EPSILON;
    logic [CFG_DATA_W-1:0]     pwdata       = '0;
    logic [CFG_DATA_W-1:0]     prdata;
    logic                      pready;

    row_loss_tracker tracker = new();
    int              push_run = 0;
    int              pop_run  = 0;

    cross_entropy_row_loss u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_prediction (i_prediction),
        .i_target     (i_target),
        .i_last_class (i_last_class),
        .pop          (pop),
        .empty        (empty),
        .o_row_loss   (o_row_loss),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Wait draw: a random idle gap before each item, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) run = $urandom_range(10, 40);
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [PRED_W-1:0] draw_prediction();
        case ($urandom_range(0, 19))
            0, 1:    return PRED_W'($urandom_range(0, 255));
            2, 3:    return PRED_W'($urandom_range(65280, 65536));
            4:       return PRED_W'($urandom_range(65537, 131071));
            default: return PRED_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [TGT_W-1:0] draw_target();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return TGT_W'(0 - $urandom_range(1, 65536));
            3:       return TGT_W'($urandom_range(65535, 65536));
            default: return TGT_W'($urandom_range(1, 65536));
        endcase
    endfunction

    // Drive one class transaction; push stays high until the next gap
    task automatic send_class(input logic [PRED_W-1:0] pred,
                              input logic signed [TGT_W-1:0] tgt, input logic last);
        int gap;
        gap = draw_wait(push_run);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_prediction <= pred;
        i_target     <= tgt;
        i_last_class <= last;
        do @(posedge i_clk); while (full);
        tracker.take_class(pred, tgt, last);
    endtask

    // Let every owed row loss drain, then give the pipeline time to empty
    task automatic settle();
        push <= 1'b0;
        while (tracker.losses_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_EPSILON;
        pwdata  <= CFG_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_epsilon(v);
    endtask

    // Rows of random length and content, last row closed on the final item
    task automatic send_random_rows(input int n_items);
        int left;
        int row_len;
        left = n_items;
        while (left > 0) begin
            row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32)
                                                  : $urandom_range(1, 8);
            if (row_len > left) row_len = left;
            for (int k = 0; k < row_len; k++)
                send_class(draw_prediction(), draw_target(), k == row_len - 1);
            left -= row_len;
        end
    endtask

    // Main stimulus
    initial begin : stimulus
        logic [EPS_W-1:0] eps_plan [6];
        eps_plan[0] = EPS_W'(0);
        eps_plan[1] = EPS_W'(32767);
        eps_plan[2] = EPS_W'(1);
        eps_plan[3] = EPS_W'($urandom_range(1, 32767));
        eps_plan[4] = EPS_W'($urandom_range(0, 32767));
        eps_plan[5] = EPS_W'(256);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset epsilon: clip at both ends, above one, zero and negative targets
        send_class(17'd0,      18'sd65536,  1'b0);
        send_class(17'd1,      18'sd65536,  1'b0);
        send_class(17'd65535,  18'sd65536,  1'b1);
        send_class(17'd65536,  18'sd65536,  1'b1);
        send_class(17'd131071, 18'sd32768,  1'b1);
        send_class(17'd32768,  18'sd0,      1'b0);
        send_class(17'd100,    -18'sd1,     1'b0);
        send_class(17'd100,    -18'sd65536, 1'b1);
        send_class(17'd43690,  18'sd1,      1'b1);
        send_class(17'd21845,  18'sd65535,  1'b0);
        send_class(17'd12345,  18'sd40000,  1'b1);
        settle();

        // epsilon zero: lower bound held at one, upper bound at one
        write_epsilon(EPS_W'(0));
        send_class(17'd0,      18'sd65536,  1'b0);
        send_class(17'd65536,  18'sd65536,  1'b1);
        send_class(17'd1,      18'sd2,      1'b1);
        settle();

        // widest epsilon: everything clips to about one half
        write_epsilon(EPS_W'(32767));
        send_class(17'd0,      18'sd65536,  1'b0);
        send_class(17'd65536,  18'sd65536,  1'b1);
        settle();

        // random rows under several clip margins
        foreach (eps_plan[i]) begin
            write_epsilon(eps_plan[i]);
            send_random_rows(PHASE_ITEMS);
            settle();
        end

        // one long row of near-zero predictions builds a large row sum
        write_epsilon(EPS_W'(1));
        for (int k = 0; k < LONG_ROW_LEN; k++)
            send_class(PRED_W'($urandom_range(0, 3)), 18'sd65536, 1'b0);
        send_class(17'd0, 18'sd65536, 1'b1);
        // the sum must start over after a long row
        send_class(17'd30000, 18'sd50000, 1'b1);
        settle();

        if (tracker.errors == 0)
            $display("cross_entropy_row_loss verification clean");
        else
            $display("cross_entropy_row_loss verification failed");
        $finish;
    end

    // Result side: pop with random stalls and check each row loss transaction
    initial begin : result_drain
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(pop_run);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            tracker.match_loss(o_row_loss);
        end
    end

    // Hang guard
    initial begin : watchdog
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("cross_entropy_row_loss verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cerl_pkg.sv
rtl/core/cerl_fifo.sv
rtl/core/cerl_front.sv
rtl/core/cerl_back.sv
rtl/core/cross_entropy_row_loss.sv
bench/tb_cross_entropy_row_loss.sv
